FILE: hdl/moving_average_deviation_ratio_top_macros.svh
// assertion macros for the moving average deviation ratio block
// expects clk and arst_n in the scope where a macro is used
`ifndef MOVING_AVERAGE_DEVIATION_RATIO_TOP_MACROS_SVH
`define MOVING_AVERAGE_DEVIATION_RATIO_TOP_MACROS_SVH

// same-cycle implication, checked out of reset only
`define MADR_ASSERT_IMP(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication, checked out of reset only
`define MADR_ASSERT_NXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: hdl/madr_pkg.sv
// shared types and constants of the moving average deviation ratio block
// no dependencies
package madr_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int PRICE_BITS = 32;
	localparam int FRAC_BITS  = 24;
	localparam int INT_BITS   = 7;
	localparam int QUO_W      = INT_BITS + FRAC_BITS;
	localparam int CNT_W      = $clog2(QUO_W);
	localparam int WIN_AW     = $clog2(MAX_WINDOW);
	localparam int EW         = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W      = PRICE_BITS + WIN_AW;
	localparam int ALU_W      = SUM_W + INT_BITS + 1;
	localparam int CFG_W      = 9;
	localparam int RATIO_W    = 32;

	localparam logic [CFG_W-1:0]   WLEN_RESET = CFG_W'(21);
	localparam logic [RATIO_W-1:0] RATIO_MAX  = 32'h7FFF_FFFF;
	localparam logic [RATIO_W-1:0] RATIO_MIN  = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] sample_price;
		logic [31:0] reference_price;
		logic        last_of_series;
	} madr_in_t;

	typedef struct packed {
		logic               ratio_valid;
		logic signed [31:0] ratio;
		logic               stopped;
		logic               series_end;
	} madr_out_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} madr_alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             carry;
	} madr_alu_rsp_t;

endpackage

FILE: hdl/moving_average_deviation_ratio_top.sv
// top level of the moving average deviation ratio block
// depends on madr_pkg, madr_alu and moving_average_deviation_ratio_top_macros.svh
//
// Usage
//   bar channel (bar_valid/bar_ready/bar): one price bar per item, the averaged
//   sample and the open price of the same bar, plus an end-of-series mark.
//   res channel (res_valid/res_ready/res): exactly one result per bar, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): window length; a write also
//   starts a new series. Taken only while no bar is in progress.
//   Each bar is processed alone: bar_ready is low from acceptance until the
//   result is placed in the output register. A bar with a valid ratio passes
//   six sequencing steps, seven for a negative deviation, then 31 restoring
//   quotient steps of one bit a cycle and one output step; a saturated quotient
//   skips the quotient steps and a bar with no ratio goes from the check step
//   to the output step. The next bar can be taken once the block is idle again.
//   The next bar may be accepted while the previous result still waits for
//   res_ready; a stalled receiver only holds the block in its final step once
//   a second result is ready. After reset: window length 21, empty window,
//   stop flag clear. The sample delay line has no reset and needs no clearing.
`include "moving_average_deviation_ratio_top_macros.svh"

module moving_average_deviation_ratio_top
	import madr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             bar_valid,
	output logic             bar_ready,
	input  madr_in_t         bar,
	output logic             res_valid,
	input  logic             res_ready,
	output madr_out_t        res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_RD   = 10'b00_0000_0010,
		ST_SUB  = 10'b00_0000_0100,
		ST_ADD  = 10'b00_0000_1000,
		ST_CHK  = 10'b00_0001_0000,
		ST_MAG  = 10'b00_0010_0000,
		ST_ABS  = 10'b00_0100_0000,
		ST_OVF  = 10'b00_1000_0000,
		ST_DIV  = 10'b01_0000_0000,
		ST_FIN  = 10'b10_0000_0000
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      wlen_q;
	logic [SUM_W-1:0]      sum_q;
	logic [EW-1:0]         fill_q;
	logic [WIN_AW-1:0]     wp_q;
	logic                  stop_q;
	logic                  res_valid_q;
	logic [CNT_W-1:0]      cnt_q;

	logic [PRICE_BITS-1:0] sample_q;
	logic [PRICE_BITS-1:0] ref_q;
	logic                  last_q;
	logic [PRICE_BITS-1:0] old_q;
	logic [SUM_W-1:0]      scaled_q;
	logic [SUM_W-1:0]      mag_q;
	logic [SUM_W-1:0]      rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic [QUO_W-1:0]      ext_q;
	logic                  neg_q;
	logic                  sat_q;
	logic                  calc_q;
	logic                  full_q;
	madr_out_t             res_q;

	logic [PRICE_BITS-1:0] win_mem [MAX_WINDOW];

	logic [EW-1:0]            w_eff;
	logic [EW:0]              wp_ext;
	logic [EW:0]              old_dist;
	logic [WIN_AW-1:0]        old_addr;
	logic [WIN_AW-1:0]        wp_next;
	logic [EW+PRICE_BITS-1:0] prod;
	logic [SUM_W:0]           div_try;
	logic                     fill_full;
	logic                     fin_go;
	logic [RATIO_W-1:0]       ratio_sel;
	madr_alu_req_t            alu_req;
	madr_alu_rsp_t            alu_rsp;

	madr_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// zero means one, anything beyond the delay line means the whole line
	always_comb begin
		if (wlen_q == '0) begin
			w_eff = EW'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			w_eff = EW'(MAX_WINDOW);
		end else begin
			w_eff = EW'(wlen_q);
		end
	end

	// slot leaving the window, modulo the delay line depth
	assign wp_ext = (EW + 1)'(wp_q);
	always_comb begin
		if (wp_ext >= (EW + 1)'(w_eff)) begin
			old_dist = wp_ext - (EW + 1)'(w_eff);
		end else begin
			old_dist = wp_ext + (EW + 1)'(MAX_WINDOW) - (EW + 1)'(w_eff);
		end
	end
	assign old_addr = old_dist[WIN_AW-1:0];
	assign wp_next  = (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + WIN_AW'(1);

	assign fill_full = (fill_q >= w_eff);
	assign prod      = (EW + PRICE_BITS)'(w_eff) * (EW + PRICE_BITS)'(ref_q);
	assign div_try   = {rem_q, ext_q[QUO_W-1]};
	assign fin_go    = (state_q == ST_FIN) && (!res_valid_q || res_ready);

	always_comb begin
		alu_req.a   = '0;
		alu_req.b   = '0;
		alu_req.sub = 1'b0;
		unique case (state_q)
			ST_SUB: begin
				alu_req.a   = ALU_W'(sum_q);
				alu_req.b   = ALU_W'(old_q);
				alu_req.sub = 1'b1;
			end
			ST_ADD: begin
				alu_req.a = ALU_W'(sum_q);
				alu_req.b = ALU_W'(sample_q);
			end
			ST_MAG: begin
				alu_req.a   = ALU_W'(sum_q);
				alu_req.b   = ALU_W'(scaled_q);
				alu_req.sub = 1'b1;
			end
			ST_ABS: begin
				alu_req.b   = ALU_W'(mag_q);
				alu_req.sub = 1'b1;
			end
			ST_OVF: begin
				// quotient of 128 or more saturates
				alu_req.a   = ALU_W'(mag_q);
				alu_req.b   = ALU_W'(sum_q) << INT_BITS;
				alu_req.sub = 1'b1;
			end
			ST_DIV: begin
				alu_req.a   = ALU_W'(div_try);
				alu_req.b   = ALU_W'(sum_q);
				alu_req.sub = 1'b1;
			end
			ST_FIN: begin
				// two's complement of the quotient when negative
				alu_req.b   = ALU_W'(quo_q);
				alu_req.sub = neg_q;
			end
			default: begin
				alu_req.sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (!calc_q) begin
			ratio_sel = '0;
		end else if (sat_q) begin
			ratio_sel = neg_q ? RATIO_MIN : RATIO_MAX;
		end else begin
			ratio_sel = alu_rsp.sum[RATIO_W-1:0];
		end
	end

	assign bar_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= WLEN_RESET;
			sum_q       <= '0;
			fill_q      <= '0;
			wp_q        <= '0;
			stop_q      <= 1'b0;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						wlen_q <= cfg_data;
						sum_q  <= '0;
						fill_q <= '0;
						wp_q   <= '0;
						stop_q <= 1'b0;
					end else if (bar_valid && bar_ready) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					if (full_q) begin
						sum_q <= alu_rsp.sum[SUM_W-1:0];
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q <= alu_rsp.sum[SUM_W-1:0];
					wp_q  <= wp_next;
					if (!full_q) begin
						fill_q <= fill_q + EW'(1);
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (fill_full && !stop_q && sum_q != '0) begin
						state_q <= ST_MAG;
					end else begin
						if (fill_full && !stop_q) begin
							stop_q <= 1'b1;
						end
						state_q <= ST_FIN;
					end
				end
				ST_MAG: begin
					state_q <= alu_rsp.carry ? ST_OVF : ST_ABS;
				end
				ST_ABS: begin
					state_q <= ST_OVF;
				end
				ST_OVF: begin
					cnt_q   <= '0;
					state_q <= alu_rsp.carry ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							sum_q  <= '0;
							fill_q <= '0;
							wp_q   <= '0;
							stop_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the item in progress
	always_ff @(posedge clk) begin
		if (bar_valid && bar_ready) begin
			sample_q <= bar.sample_price[PRICE_BITS-1:0];
			ref_q    <= bar.reference_price[PRICE_BITS-1:0];
			last_q   <= bar.last_of_series;
		end
		if (state_q == ST_RD) begin
			full_q <= fill_full;
		end
		if (state_q == ST_CHK) begin
			calc_q   <= fill_full && !stop_q && (sum_q != '0);
			scaled_q <= prod[SUM_W-1:0];
		end
		if (state_q == ST_MAG) begin
			mag_q <= alu_rsp.sum[SUM_W-1:0];
			neg_q <= !alu_rsp.carry;
		end
		if (state_q == ST_ABS) begin
			mag_q <= alu_rsp.sum[SUM_W-1:0];
		end
		if (state_q == ST_OVF) begin
			sat_q <= alu_rsp.carry;
			rem_q <= mag_q >> INT_BITS;
			ext_q <= {mag_q[INT_BITS-1:0], FRAC_BITS'(0)};
		end
		if (state_q == ST_DIV) begin
			// restoring step: one quotient bit a cycle
			ext_q <= ext_q << 1;
			if (alu_rsp.carry) begin
				rem_q <= alu_rsp.sum[SUM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= div_try[SUM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (fin_go) begin
			res_q.ratio_valid <= calc_q;
			res_q.ratio       <= ratio_sel;
			res_q.stopped     <= stop_q;
			res_q.series_end  <= last_q;
		end
	end

	// sample delay line
	always_ff @(posedge clk) begin
		if (state_q == ST_SUB) begin
			win_mem[wp_q] <= sample_q;
		end
		if (state_q == ST_RD) begin
			old_q <= win_mem[old_addr];
		end
	end

	`MADR_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= w_eff, "fill count above window length")
	`MADR_ASSERT_IMP(a_valid_not_stopped, res_valid && res.ratio_valid, !res.stopped,
		"valid ratio given with stop flag set")
	`MADR_ASSERT_NXT(a_accept_starts, bar_valid && bar_ready, state_q == ST_RD,
		"accepted item did not start the sequence")

endmodule

FILE: hdl/madr_alu.sv
// shared add/subtract unit of the moving average deviation ratio block
// depends on madr_pkg; carry out high on a subtract means a >= b
module madr_alu
	import madr_pkg::*;
(
	input  madr_alu_req_t req,
	output madr_alu_rsp_t rsp
);

	logic [ALU_W-1:0] b_op;
	logic [ALU_W:0]   total;

	assign b_op  = req.sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_op} + (ALU_W + 1)'(req.sub);

	assign rsp.sum   = total[ALU_W-1:0];
	assign rsp.carry = total[ALU_W];

endmodule

FILE: tb/sv/madr_checker.sv
`timescale 1ns / 100ps
// checker for the moving average deviation ratio block: watches the bar, result and
// window-length channels, predicts each result and compares it field by field
// depends on madr_pkg
module madr_checker
	import madr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             bar_valid,
	input  logic             bar_ready,
	input  madr_in_t         bar,
	input  logic             res_valid,
	input  logic             res_ready,
	input  madr_out_t        res,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output int               error_count,
	output int               pending
);

	logic [31:0]      delay_line [MAX_WINDOW];
	logic [39:0]      window_sum;
	logic [8:0]       samples_held;
	logic [7:0]       next_slot;
	logic             stop_seen;
	logic [CFG_W-1:0] window_len;
	madr_out_t        expected_ratios [$];
	madr_out_t        oldest;
	int               mismatches = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t madr_checker: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic clear_series();
		window_sum   = '0;
		samples_held = '0;
		next_slot    = '0;
		stop_seen    = 1'b0;
	endtask

	// one bar in, one expected result out
	task automatic predict_deviation(input madr_in_t item);
		logic [8:0]  w;
		logic [7:0]  oldest_slot;
		logic [47:0] scaled;
		logic [47:0] mag;
		logic [79:0] quot;
		logic        neg;
		madr_out_t   want;
		w = (window_len == '0) ? 9'd1 :
			(window_len > MAX_WINDOW) ? 9'(MAX_WINDOW) : window_len;
		// a window of 256 drops the slot about to be overwritten
		oldest_slot = next_slot - w[7:0];
		if (samples_held >= w)
			window_sum = window_sum - 40'(delay_line[oldest_slot]);
		delay_line[next_slot] = item.sample_price;
		window_sum = window_sum + 40'(item.sample_price);
		next_slot = next_slot + 8'd1;
		if (samples_held < w)
			samples_held = samples_held + 9'd1;
		want = '0;
		if (samples_held >= w && !stop_seen) begin
			if (window_sum == '0) begin
				stop_seen = 1'b1;
			end else begin
				scaled = 48'(w) * 48'(item.reference_price);
				neg = scaled > 48'(window_sum);
				mag = neg ? scaled - 48'(window_sum) : 48'(window_sum) - scaled;
				want.ratio_valid = 1'b1;
				if (mag >= (48'(window_sum) << 7)) begin
					want.ratio = neg ? RATIO_MIN : RATIO_MAX;
				end else begin
					// truncating divide gives the quotient rounded toward zero
					quot = 80'({mag, 24'd0}) / 80'(window_sum);
					want.ratio = neg ? ~quot[31:0] + 32'd1 : quot[31:0];
				end
			end
		end
		want.stopped = stop_seen;
		want.series_end = item.last_of_series;
		expected_ratios.push_back(want);
		if (item.last_of_series)
			clear_series();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (delay_line[i])
				delay_line[i] = '0;
			window_len = WLEN_RESET;
			clear_series();
			expected_ratios.delete();
		end else begin
			// a result taken now always belongs to an earlier bar
			if (res_valid && res_ready) begin
				if (expected_ratios.size() == 0) begin
					report_mismatch("result item with nothing expected, ratio", res.ratio, '0);
				end else begin
					oldest = expected_ratios.pop_front();
					if (res.ratio_valid !== oldest.ratio_valid)
						report_mismatch("ratio_valid", 32'(res.ratio_valid), 32'(oldest.ratio_valid));
					if (res.ratio !== oldest.ratio)
						report_mismatch("ratio", res.ratio, oldest.ratio);
					if (res.stopped !== oldest.stopped)
						report_mismatch("stopped", 32'(res.stopped), 32'(oldest.stopped));
					if (res.series_end !== oldest.series_end)
						report_mismatch("series_end", 32'(res.series_end), 32'(oldest.series_end));
				end
			end
			if (cfg_valid && cfg_ready) begin
				window_len = cfg_data;
				clear_series();
			end
			if (bar_valid && bar_ready)
				predict_deviation(bar);
		end
		pending <= expected_ratios.size();
		error_count <= mismatches;
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// top of the moving average deviation ratio testbench: clock, reset, bar and window
// stimulus, result back-pressure and the verdict; depends on madr_pkg, madr_checker
// and moving_average_deviation_ratio_top
module tb_top;
	import madr_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 64;
	localparam int NUM_PHASES   = 11;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             bar_valid = 1'b0;
	logic             bar_ready;
	madr_in_t         bar       = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	madr_out_t        res;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	int errors_seen;
	int results_due;
	int idle_pct     = 33;
	int hold_seq     = 0;
	int quiet_cycles = 0;

	moving_average_deviation_ratio_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar_valid (bar_valid),
		.bar_ready (bar_ready),
		.bar       (bar),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	madr_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.bar_valid   (bar_valid),
		.bar_ready   (bar_ready),
		.bar         (bar),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.error_count (errors_seen),
		.pending     (results_due)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ends the run if the channels go quiet for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((bar_valid && bar_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// result side: random back-pressure, plus a long hold whenever hold_seq moves
	initial begin : receiver
		int hold_left;
		int seen_hold;
		hold_left = 0;
		seen_hold = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_seq != seen_hold) begin
				seen_hold = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// offer one bar item and return at the edge where it is taken; valid stays high
	task automatic offer_bar(input logic [31:0] sample, input logic [31:0] open_price,
		input logic last);
		madr_in_t item;
		item = '{sample_price: sample, reference_price: open_price, last_of_series: last};
		while ($urandom_range(99) < idle_pct) begin
			bar_valid <= 1'b0;
			@(posedge clk);
		end
		bar_valid <= 1'b1;
		bar <= item;
		@(posedge clk);
		while (!bar_ready)
			@(posedge clk);
	endtask

	task automatic wait_results_drained();
		bar_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] len);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int               phase_cfg [NUM_PHASES];
		int               p;
		int               k;
		int               len;
		int               mode;
		int               z0;
		int               w_eff;
		int               n_items;
		int               sent;
		longint unsigned  base;
		longint unsigned  spread;
		longint unsigned  s;
		longint unsigned  r;
		logic             last;
		logic [CFG_W-1:0] cfg_val;

		phase_cfg = '{3, 8, 21, 55, 144, 1, 2, 256, 511, 0, 0};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of 21: a short series never fills it
		offer_bar(32'd5, 32'd5, 1'b0);
		offer_bar(32'd7, 32'd3, 1'b0);
		offer_bar(32'd9, 32'd9, 1'b1);

		write_window(9'd1);
		offer_bar(32'd0, 32'd17, 1'b0);              // zero sum sets the stop flag
		offer_bar(32'd5, 32'd5, 1'b0);               // stop is sticky
		offer_bar(32'd0, 32'd0, 1'b1);               // end of series clears it
		offer_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		offer_bar(32'd1, 32'd0, 1'b0);
		offer_bar(32'hFFFF_FFFF, 32'd0, 1'b0);
		offer_bar(32'd100, 32'd1, 1'b0);
		offer_bar(32'd3, 32'd1, 1'b0);
		offer_bar(32'd3, 32'd5, 1'b0);               // negative, rounded toward zero
		offer_bar(32'd1, 32'd128, 1'b0);             // just below saturation
		offer_bar(32'd1, 32'd129, 1'b0);             // just at saturation
		offer_bar(32'd1, 32'hFFFF_FFFF, 1'b1);

		write_window(9'd0);                          // zero length acts as one
		offer_bar(32'd7, 32'd6, 1'b0);
		offer_bar(32'd0, 32'd1, 1'b1);               // stop and end on the same item

		write_window(9'd300);                        // clamped to the deepest window
		offer_bar(32'd2, 32'd3, 1'b0);
		offer_bar(32'd4, 32'd4, 1'b1);

		write_window(9'd2);
		offer_bar(32'd10, 32'd0, 1'b0);
		offer_bar(32'd0, 32'd9, 1'b0);
		offer_bar(32'd0, 32'd0, 1'b0);               // window empties to zero
		offer_bar(32'd6, 32'd2, 1'b1);

		for (p = 0; p < NUM_PHASES; p++) begin
			cfg_val = (phase_cfg[p] == 0) ? CFG_W'($urandom_range(1, 40)) : CFG_W'(phase_cfg[p]);
			write_window(cfg_val);
			w_eff = (cfg_val > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_val);
			n_items = (w_eff <= 21) ? 80 : w_eff + 40;
			idle_pct <= (p == 3) ? 0 : 33;
			if (p == 4)
				hold_seq <= hold_seq + 1;
			sent = 0;
			while (sent < n_items) begin
				mode = $urandom_range(99);
				base = 64'($urandom >> $urandom_range(0, 31));
				spread = base >> 3;
				z0 = $urandom_range(0, w_eff);
				if (mode < 12)
					len = $urandom_range(1, w_eff);
				else if (mode < 22 && w_eff <= 55)
					len = z0 + w_eff + $urandom_range(0, 8);
				else
					len = w_eff + $urandom_range(0, w_eff + 20);
				if (len > n_items - sent)
					len = n_items - sent;
				for (k = 0; k < len; k++) begin
					last = (k == len - 1);
					r = base + $urandom_range(0, 32'(spread));
					s = base + $urandom_range(0, 32'(spread));
					if (mode < 12) begin
						// noise: any values, stray series ends
						s = $urandom;
						r = $urandom;
						last = last || ($urandom_range(7) == 0);
					end else if (mode < 22 && w_eff <= 55) begin
						// a full window of zeros, then more prices while stopped
						if (k >= z0 && k < z0 + w_eff)
							s = 0;
						r = $urandom;
					end else if ($urandom_range(9) == 0) begin
						r = $urandom;
					end
					if (s > 64'hFFFF_FFFF)
						s = 64'hFFFF_FFFF;
					if (r > 64'hFFFF_FFFF)
						r = 64'hFFFF_FFFF;
					offer_bar(32'(s), 32'(r), last);
				end
				sent += len;
			end
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors_seen == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
